### hw/rtl/dgr_pkg.sv
`default_nettype none
package dgr_pkg;

    // Glyph geometry and digit count
    localparam int DIGIT_W    = 30;
    localparam int DIGIT_H    = 50;
    localparam int DIGIT_GAP  = 10;
    localparam int MAX_DIGITS = 3;

    // Derived sizes
    localparam int CELL_W      = DIGIT_W / 3;
    localparam int CELL_H      = DIGIT_H / 5;
    localparam int DIGIT_PITCH = DIGIT_W + DIGIT_GAP;
    localparam int NUM_LIMIT   = (10 ** MAX_DIGITS) - 1;
    localparam int DIG_IW      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Field widths
    localparam int NUM_W   = 10;
    localparam int ORG_W   = 12;
    localparam int COORD_W = 13;
    localparam int CELLS   = 15;

    // Reciprocal of ten for values below 1029: q = (v * 205) >> 11
    localparam int RECIP10   = 205;
    localparam int RECIP_SH  = 11;
    localparam int PROD_W    = NUM_W + 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic item_done;
        logic out_free;
    } t_status;

    // Lit cells of a digit, bit r*3+c for row r and column c (column 0 left)
    function automatic logic [CELLS-1:0] f_glyph(input logic [3:0] d);
        logic [2:0]       rows [5];
        logic [CELLS-1:0] g;
        unique case (d)
            4'd0:    rows = '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    rows = '{3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
            4'd2:    rows = '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd3:    rows = '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            4'd4:    rows = '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            4'd5:    rows = '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd6:    rows = '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            4'd7:    rows = '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
            4'd8:    rows = '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    rows = '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            default: rows = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
        endcase
        g = '0;
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 3; c++) begin
                g[r * 3 + c] = rows[r][2 - c];
            end
        end
        return g;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/decimal_digit_glyph_rect_generator.sv
// A number is accepted in the idle state, its digits are extracted one by one
// (1 to MAX_DIGITS) in the convert state, and the rectangles are registered
// in the emit state, one rectangle per cycle unless i_ready stalls the output;
// a new number is accepted only after the last rectangle of the old one is emitted.
// Reset (synchronous, active low) returns the controller to idle and drops o_valid.
`default_nettype none
module decimal_digit_glyph_rect_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [dgr_pkg::NUM_W-1:0]     i_number,
    input  wire logic [dgr_pkg::ORG_W-1:0]     i_origin_x,
    input  wire logic [dgr_pkg::ORG_W-1:0]     i_origin_y,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dgr_pkg::COORD_W-1:0]        o_rect_x,
    output logic [dgr_pkg::COORD_W-1:0]        o_rect_y,
    output logic                               o_last
);

    dgr_pkg::t_cmd    cmd;
    dgr_pkg::t_status status;

    dgr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dgr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_number   (i_number),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rect_x   (o_rect_x),
        .o_rect_y   (o_rect_y),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

### hw/rtl/dgr_ctrl.sv
`default_nettype none
module dgr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire dgr_pkg::t_status i_status,
    output dgr_pkg::t_cmd         o_cmd
);

    dgr_pkg::t_state r_state;
    dgr_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = dgr_pkg::ST_CONV;
                end
            end
            dgr_pkg::ST_CONV: begin
                if (i_status.conv_done) begin
                    n_state = dgr_pkg::ST_EMIT;
                end
            end
            dgr_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.item_done) begin
                    n_state = dgr_pkg::ST_IDLE;
                end
            end
            default: n_state = dgr_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            dgr_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            dgr_pkg::ST_CONV: begin
                o_cmd.conv = 1'b1;
            end
            dgr_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/dgr_dp.sv
`default_nettype none
module dgr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dgr_pkg::t_cmd                 i_cmd,
    output dgr_pkg::t_status                   o_status,
    input  wire logic [dgr_pkg::NUM_W-1:0]     i_number,
    input  wire logic [dgr_pkg::ORG_W-1:0]     i_origin_x,
    input  wire logic [dgr_pkg::ORG_W-1:0]     i_origin_y,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dgr_pkg::COORD_W-1:0]        o_rect_x,
    output logic [dgr_pkg::COORD_W-1:0]        o_rect_y,
    output logic                               o_last
);

    localparam int NW = dgr_pkg::NUM_W;
    localparam int CW = dgr_pkg::COORD_W;
    localparam int IW = dgr_pkg::DIG_IW;

    logic [NW-1:0]              r_value;
    logic [IW-1:0]              r_cnt;
    logic [IW-1:0]              r_k;
    logic [3:0]                 r_digits [dgr_pkg::MAX_DIGITS];
    logic [dgr_pkg::CELLS-1:0]  r_mask;
    logic [CW-1:0]              r_dx;
    logic [CW-1:0]              r_oy;
    logic                       r_out_valid;
    logic [CW-1:0]              r_rect_x;
    logic [CW-1:0]              r_rect_y;
    logic                       r_last;

    logic [NW-1:0]              sat_value;
    logic [dgr_pkg::PROD_W-1:0] prod;
    logic [NW-1:0]              quot;
    logic [3:0]                 rem;
    logic                       conv_done;
    logic [2:0]                 sel_r;
    logic [1:0]                 sel_c;
    logic                       single;
    logic [IW-1:0]              k_next;

    // Saturate the number to the largest value the digits can show
    always_comb begin
        if ({4'd0, i_number} > 14'(dgr_pkg::NUM_LIMIT)) begin
            sat_value = NW'(dgr_pkg::NUM_LIMIT);
        end else begin
            sat_value = i_number;
        end
    end

    // Divide by ten through the reciprocal
    assign prod      = dgr_pkg::PROD_W'(r_value) * dgr_pkg::PROD_W'(dgr_pkg::RECIP10);
    assign quot      = NW'(prod >> dgr_pkg::RECIP_SH);
    assign rem       = 4'(r_value - NW'(quot * NW'(10)));
    assign conv_done = (quot == '0) || (r_cnt == IW'(dgr_pkg::MAX_DIGITS - 1));

    // Pick the first lit cell left in scan order
    always_comb begin
        sel_r = '0;
        sel_c = '0;
        for (int r = 4; r >= 0; r--) begin
            for (int c = 2; c >= 0; c--) begin
                if (r_mask[r * 3 + c]) begin
                    sel_r = 3'(r);
                    sel_c = 2'(c);
                end
            end
        end
    end

    assign single = ((r_mask & (r_mask - 1'b1)) == '0);
    assign k_next = r_k - 1'b1;

    // Load the item, extract digits, walk the glyph cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= sat_value;
            r_cnt   <= '0;
            r_dx    <= CW'(i_origin_x);
            r_oy    <= CW'(i_origin_y);
        end else if (i_cmd.conv) begin
            r_digits[r_cnt] <= rem;
            if (conv_done) begin
                r_k    <= r_cnt;
                r_mask <= dgr_pkg::f_glyph(rem);
            end else begin
                r_cnt   <= r_cnt + 1'b1;
                r_value <= quot;
            end
        end else if (i_cmd.emit) begin
            r_rect_x <= r_dx + CW'(CW'(sel_c) * CW'(dgr_pkg::CELL_W));
            r_rect_y <= r_oy + CW'(CW'(sel_r) * CW'(dgr_pkg::CELL_H));
            r_last   <= single && (r_k == '0);
            if (single) begin
                if (r_k != '0) begin
                    r_k    <= k_next;
                    r_mask <= dgr_pkg::f_glyph(r_digits[k_next]);
                    r_dx   <= r_dx + CW'(dgr_pkg::DIGIT_PITCH);
                end
            end else begin
                r_mask <= r_mask & (r_mask - 1'b1);
            end
        end
    end

    // Hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.conv_done = conv_done;
    assign o_status.item_done = single && (r_k == '0);
    assign o_status.out_free  = !r_out_valid || i_ready;

    assign o_valid  = r_out_valid;
    assign o_rect_x = r_rect_x;
    assign o_rect_y = r_rect_y;
    assign o_last   = r_last;

endmodule
`default_nettype wire

### tb/decimal_digit_glyph_rect_generator_test.sv
`default_nettype none
module decimal_digit_glyph_rect_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 138;

    typedef struct {
        logic [dgr_pkg::NUM_W-1:0] num;
        logic [dgr_pkg::ORG_W-1:0] ox;
        logic [dgr_pkg::ORG_W-1:0] oy;
    } t_number_req;

    typedef struct {
        logic [dgr_pkg::COORD_W-1:0] x;
        logic [dgr_pkg::COORD_W-1:0] y;
        logic                        last;
    } t_rect;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          o_ready;
    logic [dgr_pkg::NUM_W-1:0]     i_number   = '0;
    logic [dgr_pkg::ORG_W-1:0]     i_origin_x = '0;
    logic [dgr_pkg::ORG_W-1:0]     i_origin_y = '0;
    logic                          o_valid;
    logic                          i_ready    = 1'b0;
    logic [dgr_pkg::COORD_W-1:0]   o_rect_x;
    logic [dgr_pkg::COORD_W-1:0]   o_rect_y;
    logic                          o_last;

    t_number_req numbers_to_send[$];
    t_rect       due_rects[$];
    int          numbers_taken  = 0;
    int          rects_drawn    = 0;
    int          mismatch_count = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    int          quiet_cycles   = 0;
    bit          send_idle;
    t_number_req next_req;
    t_rect       want;

    decimal_digit_glyph_rect_generator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_number   (i_number),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rect_x   (o_rect_x),
        .o_rect_y   (o_rect_y),
        .o_last     (o_last)
    );

    always #1 i_clk = ~i_clk;

    // 3x5 font, top row in the high bits, left column first within a row
    function automatic logic [14:0] font_word(input int digit);
        case (digit)
            0:       return 15'b111_101_101_101_111;
            1:       return 15'b010_010_010_010_010;
            2:       return 15'b111_001_111_100_111;
            3:       return 15'b111_001_111_001_111;
            4:       return 15'b101_101_111_001_001;
            5:       return 15'b111_100_111_001_111;
            6:       return 15'b111_100_111_101_111;
            7:       return 15'b111_001_001_001_001;
            8:       return 15'b111_101_111_101_111;
            default: return 15'b111_101_111_001_111;
        endcase
    endfunction

    // Expand one number into its lit-cell rectangles, most significant digit first
    task automatic expand_number(input logic [dgr_pkg::NUM_W-1:0] num,
                                 input logic [dgr_pkg::ORG_W-1:0] ox,
                                 input logic [dgr_pkg::ORG_W-1:0] oy);
        int          value;
        int          limit;
        int          digits[$];
        logic [14:0] bits;
        t_rect       item_rects[$];
        t_rect       rect;
        limit = 1;
        for (int i = 0; i < dgr_pkg::MAX_DIGITS; i++) limit = limit * 10;
        limit = limit - 1;
        value = num;
        // Saturate to all nines
        if (value > limit) value = limit;
        do begin
            digits.push_front(value % 10);
            value = value / 10;
        end while (value != 0 && digits.size() < dgr_pkg::MAX_DIGITS);
        foreach (digits[k]) begin
            bits = font_word(digits[k]);
            for (int row = 0; row < 5; row++) begin
                for (int col = 0; col < 3; col++) begin
                    if (bits[14 - 3 * row - col]) begin
                        rect.x    = dgr_pkg::COORD_W'(int'(ox)
                                    + k * (dgr_pkg::DIGIT_W + dgr_pkg::DIGIT_GAP)
                                    + col * (dgr_pkg::DIGIT_W / 3));
                        rect.y    = dgr_pkg::COORD_W'(int'(oy)
                                    + row * (dgr_pkg::DIGIT_H / 5));
                        rect.last = 1'b0;
                        item_rects.push_back(rect);
                    end
                end
            end
        end
        item_rects[item_rects.size() - 1].last = 1'b1;
        foreach (item_rects[i]) due_rects.push_back(item_rects[i]);
    endtask

    task automatic queue_number(input int num, input int ox, input int oy);
        t_number_req req;
        req.num = dgr_pkg::NUM_W'(num);
        req.ox  = dgr_pkg::ORG_W'(ox);
        req.oy  = dgr_pkg::ORG_W'(oy);
        numbers_to_send.push_back(req);
    endtask

    // Reset once at the start
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: record the transfer, then offer the next number unless idling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expand_number(i_number, i_origin_x, i_origin_y);
                numbers_taken++;
            end
            if (!i_valid || o_ready) begin
                send_idle = !(numbers_taken >= 60 && numbers_taken < 100)
                            && ($urandom_range(99) < 15);
                if (numbers_to_send.size() != 0 && !send_idle) begin
                    next_req = numbers_to_send.pop_front();
                    i_valid    <= 1'b1;
                    i_number   <= next_req.num;
                    i_origin_x <= next_req.ox;
                    i_origin_y <= next_req.oy;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each rectangle against the oldest expected one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_rects.size() == 0) begin
                    $error("unexpected rectangle x=%0d y=%0d last=%0d",
                           o_rect_x, o_rect_y, o_last);
                    mismatch_count++;
                end else begin
                    want = due_rects.pop_front();
                    if (o_rect_x !== want.x) begin
                        $error("rect_x: expected %0d, got %0d", want.x, o_rect_x);
                        mismatch_count++;
                    end
                    if (o_rect_y !== want.y) begin
                        $error("rect_y: expected %0d, got %0d", want.y, o_rect_y);
                        mismatch_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        mismatch_count++;
                    end
                end
                rects_drawn++;
            end
            // Hold off once for a long stretch so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && rects_drawn >= 1000) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (rects_drawn >= 2000 && rects_drawn < 3000) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial begin
        int total;
        int sel;
        int num;
        // Every glyph, coordinate extremes
        queue_number(0, 0, 0);
        queue_number(1, 4095, 4095);
        queue_number(2, 0, 4095);
        queue_number(3, 4095, 0);
        queue_number(4, 2730, 1365);
        queue_number(5, 1365, 2730);
        queue_number(6, 100, 200);
        queue_number(7, 3000, 17);
        queue_number(8, 8, 4000);
        queue_number(9, 4095, 4095);
        // Digit counts, interior zeros, saturation
        queue_number(10, 4095, 4095);
        queue_number(99, 0, 0);
        queue_number(100, 4095, 4095);
        queue_number(105, 12, 34);
        queue_number(123, 500, 600);
        queue_number(456, 4095, 0);
        queue_number(789, 0, 4095);
        queue_number(999, 4095, 4095);
        queue_number(1000, 0, 0);
        queue_number(1023, 4095, 4095);
        queue_number(512, 2048, 2048);
        queue_number(680, 1, 1);
        // Random numbers, weighted across digit counts
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sel = $urandom_range(99);
            if (sel < 10)      num = $urandom_range(9);
            else if (sel < 30) num = $urandom_range(99, 10);
            else if (sel < 88) num = $urandom_range(999, 100);
            else               num = $urandom_range(1023, 1000);
            queue_number(num, $urandom_range(4095), $urandom_range(4095));
        end
        total = numbers_to_send.size();

        wait (numbers_taken == total);
        wait (due_rects.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hw/rtl/dgr_pkg.sv
hw/rtl/dgr_ctrl.sv
hw/rtl/dgr_dp.sv
hw/rtl/decimal_digit_glyph_rect_generator.sv
tb/decimal_digit_glyph_rect_generator_test.sv
